/* rtl/brf_pkg.sv */
// brf_pkg: types, codes and float helpers for the bracketed root finder
`timescale 1ns / 1ps

package brf_pkg;

    localparam int BISECT_PERIOD_DEF = 5;
    localparam int EW = 14;

    localparam logic       OP_START = 1'b0;
    localparam logic       OP_VALUE = 1'b1;

    localparam logic [1:0] KIND_EVAL = 2'd0;
    localparam logic [1:0] KIND_ROOT = 2'd1;
    localparam logic [1:0] KIND_NOBR = 2'd2;
    localparam logic [1:0] KIND_IDLE = 2'd3;

    localparam logic [63:0] ONE_HALF = 64'h3FE0_0000_0000_0000;
    localparam logic [63:0] DEF_NAN  = 64'hFFF8_0000_0000_0000;
    localparam logic [62:0] INF_MAG  = 63'h7FF0_0000_0000_0000;

    typedef struct packed {
        logic        operation;
        logic [63:0] bound_a;
        logic [63:0] bound_b;
        logic [63:0] func_value;
    } t_in;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] point;
    } t_out;

    typedef enum logic [1:0] {FOP_ADD, FOP_SUB, FOP_MUL, FOP_DIV} t_fop;

    typedef struct packed {
        logic        start;
        t_fop        op;
        logic [63:0] a;
        logic [63:0] b;
    } t_fpu_req;

    typedef struct packed {
        logic        done;
        logic [63:0] res;
    } t_fpu_rsp;

    typedef enum logic [3:0] {
        F_IDLE, F_PRE, F_ADD, F_MUL, F_MULF, F_DIV, F_DIVF,
        F_NORM, F_DENORM, F_ROUND, F_DONE
    } t_fstate;

    typedef enum logic [3:0] {
        S_IDLE, S_START2, S_PROD, S_ADV, S_SUM, S_MID, S_DEN,
        S_T1, S_T2, S_NUM, S_DIV, S_FIN, S_EMIT
    } t_state;

    typedef enum logic [1:0] {SP_IDLE, SP_WAIT_LO, SP_WAIT_HI, SP_WAIT_PT} t_search;

    function automatic logic fp_is_nan(input logic [63:0] x);
        return (&x[62:52]) && (|x[51:0]);
    endfunction

    function automatic logic fp_is_inf(input logic [63:0] x);
        return (&x[62:52]) && !(|x[51:0]);
    endfunction

    function automatic logic fp_is_zero(input logic [63:0] x);
        return x[62:0] == 63'd0;
    endfunction

    function automatic logic [63:0] fp_quiet(input logic [63:0] x);
        return x | (64'd1 << 51);
    endfunction

    function automatic logic fp_eq(input logic [63:0] a, input logic [63:0] b);
        return !fp_is_nan(a) && !fp_is_nan(b) &&
               ((a == b) || (fp_is_zero(a) && fp_is_zero(b)));
    endfunction

    function automatic logic fp_lt(input logic [63:0] a, input logic [63:0] b);
        logic r;
        if (fp_is_nan(a) || fp_is_nan(b) || (fp_is_zero(a) && fp_is_zero(b))) begin
            r = 1'b0;
        end else if (a[63] != b[63]) begin
            r = a[63];
        end else if (!a[63]) begin
            r = a[62:0] < b[62:0];
        end else begin
            r = a[62:0] > b[62:0];
        end
        return r;
    endfunction

    function automatic logic fp_le(input logic [63:0] a, input logic [63:0] b);
        return fp_lt(a, b) || fp_eq(a, b);
    endfunction

    function automatic logic fp_pos(input logic [63:0] x);
        return !fp_is_nan(x) && !x[63] && !fp_is_zero(x);
    endfunction

    function automatic logic fp_neg(input logic [63:0] x);
        return !fp_is_nan(x) && x[63] && !fp_is_zero(x);
    endfunction

    // one ulp from p toward q
    function automatic logic [63:0] fp_ulp_toward(input logic [63:0] p, input logic [63:0] q);
        logic [63:0] r;
        if (fp_is_nan(p)) begin
            r = fp_quiet(p);
        end else if (fp_is_nan(q)) begin
            r = fp_quiet(q);
        end else if (fp_eq(p, q)) begin
            r = q;
        end else if (fp_is_zero(p)) begin
            r = {q[63], 63'd1};
        end else if (fp_lt(p, q) == !p[63]) begin
            r = p + 64'd1;
        end else begin
            r = p - 64'd1;
        end
        return r;
    endfunction

endpackage

/* rtl/brf_fpu.sv */
// brf_fpu: shared multicycle double add, subtract, multiply and divide unit
`timescale 1ns / 1ps

module brf_fpu import brf_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_fpu_req i_req,
    output t_fpu_rsp o_rsp
);

    localparam logic signed [EW-1:0] EMIN = -14'sd1022;

    t_fstate r_fst, n_fst;
    t_fop    r_op, n_op;
    logic    r_sa, n_sa, r_sb, n_sb, r_swap, n_swap, r_sign, n_sign, r_stk, n_stk;
    logic signed [EW-1:0] r_ea, n_ea, r_eb, n_eb, r_e, n_e;
    logic [52:0]  r_ma, n_ma, r_mb, n_mb;
    logic [63:0]  r_m, n_m, r_q, n_q, r_res, n_res;
    logic [105:0] r_acc, n_acc;
    logic [53:0]  r_pp, n_pp;
    logic [5:0]   r_psh, n_psh, r_cnt, n_cnt;
    logic [53:0]  r_rem, n_rem;

    function automatic logic signed [EW-1:0] unp_e(input logic [63:0] x);
        return (x[62:52] == 11'd0) ? EMIN : ($signed({3'b000, x[62:52]}) - 14'sd1023);
    endfunction

    function automatic logic [52:0] unp_m(input logic [63:0] x);
        return {x[62:52] != 11'd0, x[51:0]};
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fst <= F_IDLE;
        end else begin
            r_fst <= n_fst;
        end
        r_op   <= n_op;
        r_sa   <= n_sa;
        r_sb   <= n_sb;
        r_swap <= n_swap;
        r_sign <= n_sign;
        r_stk  <= n_stk;
        r_ea   <= n_ea;
        r_eb   <= n_eb;
        r_e    <= n_e;
        r_ma   <= n_ma;
        r_mb   <= n_mb;
        r_m    <= n_m;
        r_q    <= n_q;
        r_res  <= n_res;
        r_acc  <= n_acc;
        r_pp   <= n_pp;
        r_psh  <= n_psh;
        r_cnt  <= n_cnt;
        r_rem  <= n_rem;
    end

    always_comb begin
        logic [63:0] a, b, xb, xs0, xs, sum;
        logic        sbe, sp, lost, ge, inc;
        logic signed [EW-1:0] d, eb_big, es_sm, biased, ef;
        logic [52:0] mb_big, ms_sm, qf;
        logic [53:0] rsub, qs;
        logic [26:0] ap, bp;
        logic [5:0]  sh;

        n_fst  = r_fst;
        n_op   = r_op;
        n_sa   = r_sa;
        n_sb   = r_sb;
        n_swap = r_swap;
        n_sign = r_sign;
        n_stk  = r_stk;
        n_ea   = r_ea;
        n_eb   = r_eb;
        n_e    = r_e;
        n_ma   = r_ma;
        n_mb   = r_mb;
        n_m    = r_m;
        n_q    = r_q;
        n_res  = r_res;
        n_acc  = r_acc;
        n_pp   = r_pp;
        n_psh  = r_psh;
        n_cnt  = r_cnt;
        n_rem  = r_rem;

        a   = i_req.a;
        b   = i_req.b;
        sbe = b[63] ^ (i_req.op == FOP_SUB);
        sp  = a[63] ^ b[63];
        xb = '0; xs0 = '0; xs = '0; sum = '0; lost = 1'b0; ge = 1'b0; inc = 1'b0;
        d = '0; eb_big = '0; es_sm = '0; biased = '0; ef = '0;
        mb_big = '0; ms_sm = '0; qf = '0; rsub = '0; qs = '0; ap = '0; bp = '0; sh = '0;

        case (r_fst)
            F_IDLE, F_DONE: begin
                n_fst = F_IDLE;
                if (i_req.start) begin
                    n_op   = i_req.op;
                    n_sa   = a[63];
                    n_sb   = sbe;
                    n_swap = a[62:0] < b[62:0];
                    n_ea   = unp_e(a);
                    n_eb   = unp_e(b);
                    n_ma   = unp_m(a);
                    n_mb   = unp_m(b);
                    n_sign = sp;
                    n_fst  = F_DONE;
                    case (i_req.op)
                        FOP_ADD, FOP_SUB: begin
                            if (fp_is_nan(a)) begin
                                n_res = fp_quiet(a);
                            end else if (fp_is_nan(b)) begin
                                n_res = fp_quiet(b);
                            end else if (fp_is_inf(a)) begin
                                n_res = (fp_is_inf(b) && (a[63] != sbe)) ? DEF_NAN : a;
                            end else if (fp_is_inf(b)) begin
                                n_res = {sbe, INF_MAG};
                            end else if (fp_is_zero(a) && fp_is_zero(b)) begin
                                n_res = {a[63] & sbe, 63'd0};
                            end else begin
                                n_fst = F_ADD;
                            end
                        end
                        FOP_MUL: begin
                            if (fp_is_nan(a)) begin
                                n_res = fp_quiet(a);
                            end else if (fp_is_nan(b)) begin
                                n_res = fp_quiet(b);
                            end else if ((fp_is_inf(a) && fp_is_zero(b)) ||
                                         (fp_is_zero(a) && fp_is_inf(b))) begin
                                n_res = DEF_NAN;
                            end else if (fp_is_inf(a) || fp_is_inf(b)) begin
                                n_res = {sp, INF_MAG};
                            end else if (fp_is_zero(a) || fp_is_zero(b)) begin
                                n_res = {sp, 63'd0};
                            end else begin
                                n_fst = F_PRE;
                            end
                        end
                        default: begin
                            if (fp_is_nan(a)) begin
                                n_res = fp_quiet(a);
                            end else if (fp_is_nan(b)) begin
                                n_res = fp_quiet(b);
                            end else if ((fp_is_inf(a) && fp_is_inf(b)) ||
                                         (fp_is_zero(a) && fp_is_zero(b))) begin
                                n_res = DEF_NAN;
                            end else if (fp_is_inf(a)) begin
                                n_res = {sp, INF_MAG};
                            end else if (fp_is_inf(b)) begin
                                n_res = {sp, 63'd0};
                            end else if (fp_is_zero(b)) begin
                                n_res = {sp, INF_MAG};
                            end else if (fp_is_zero(a)) begin
                                n_res = {sp, 63'd0};
                            end else begin
                                n_fst = F_PRE;
                            end
                        end
                    endcase
                end
            end
            F_PRE: begin
                if (!r_ma[52]) begin
                    n_ma = {r_ma[51:0], 1'b0};
                    n_ea = r_ea - 14'sd1;
                end else if (!r_mb[52]) begin
                    n_mb = {r_mb[51:0], 1'b0};
                    n_eb = r_eb - 14'sd1;
                end else if (r_op == FOP_MUL) begin
                    n_acc = '0;
                    n_cnt = '0;
                    n_fst = F_MUL;
                end else begin
                    n_rem = {1'b0, r_ma};
                    n_q   = '0;
                    n_cnt = '0;
                    n_fst = F_DIV;
                end
            end
            F_ADD: begin
                eb_big = r_swap ? r_eb : r_ea;
                es_sm  = r_swap ? r_ea : r_eb;
                mb_big = r_swap ? r_mb : r_ma;
                ms_sm  = r_swap ? r_ma : r_mb;
                d      = eb_big - es_sm;
                xb     = {1'b0, mb_big, 10'd0};
                xs0    = {1'b0, ms_sm, 10'd0};
                if (d >= 14'sd64) begin
                    xs   = '0;
                    lost = ms_sm != 53'd0;
                end else begin
                    sh   = d[5:0];
                    xs   = xs0 >> sh;
                    lost = |(xs0 & ~({64{1'b1}} << sh));
                end
                xs  = xs | {63'd0, lost};
                sum = (r_sa == r_sb) ? (xb + xs) : (xb - xs);
                if (sum == 64'd0) begin
                    n_res = 64'd0;
                    n_fst = F_DONE;
                end else begin
                    n_m    = sum;
                    n_e    = eb_big + 14'sd1;
                    n_sign = r_swap ? r_sb : r_sa;
                    n_stk  = 1'b0;
                    n_fst  = F_NORM;
                end
            end
            F_MUL: begin
                ap = r_cnt[1] ? {1'b0, r_ma[52:27]} : r_ma[26:0];
                bp = r_cnt[0] ? {1'b0, r_mb[52:27]} : r_mb[26:0];
                if (r_cnt != 6'd0) begin
                    n_acc = r_acc + ({52'd0, r_pp} << r_psh);
                end
                if (r_cnt == 6'd4) begin
                    n_fst = F_MULF;
                end else begin
                    n_pp  = {27'd0, ap} * {27'd0, bp};
                    n_psh = (r_cnt[1] ? 6'd27 : 6'd0) + (r_cnt[0] ? 6'd27 : 6'd0);
                    n_cnt = r_cnt + 6'd1;
                end
            end
            F_MULF: begin
                n_m   = r_acc[105:42];
                n_stk = |r_acc[41:0];
                n_e   = r_ea + r_eb + 14'sd1;
                n_fst = F_NORM;
            end
            F_DIV: begin
                ge    = r_rem >= {1'b0, r_mb};
                rsub  = ge ? (r_rem - {1'b0, r_mb}) : r_rem;
                n_rem = {rsub[52:0], 1'b0};
                n_q   = {r_q[62:0], ge};
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    n_fst = F_DIVF;
                end
            end
            F_DIVF: begin
                n_m   = r_q;
                n_stk = r_rem != 54'd0;
                n_e   = r_ea - r_eb;
                n_fst = F_NORM;
            end
            F_NORM: begin
                if (r_m[63]) begin
                    n_fst = F_DENORM;
                end else begin
                    n_m = {r_m[62:0], 1'b0};
                    n_e = r_e - 14'sd1;
                end
            end
            F_DENORM: begin
                if (r_e < EMIN) begin
                    d = EMIN - r_e;
                    if (d >= 14'sd64) begin
                        n_m   = '0;
                        n_stk = r_stk | (r_m != 64'd0);
                    end else begin
                        sh    = d[5:0];
                        n_m   = r_m >> sh;
                        n_stk = r_stk | (|(r_m & ~({64{1'b1}} << sh)));
                    end
                    n_e = EMIN;
                end
                n_fst = F_ROUND;
            end
            F_ROUND: begin
                inc = r_m[10] & ((|r_m[9:0]) | r_stk | r_m[11]);
                qs  = {1'b0, r_m[63:11]} + {53'd0, inc};
                if (qs[53]) begin
                    qf = qs[53:1];
                    ef = r_e + 14'sd1;
                end else begin
                    qf = qs[52:0];
                    ef = r_e;
                end
                biased = ef + 14'sd1023;
                if (biased >= 14'sd2047) begin
                    n_res = {r_sign, INF_MAG};
                end else begin
                    n_res = {r_sign, (qf[52] ? biased[10:0] : 11'd0), qf[51:0]};
                end
                n_fst = F_DONE;
            end
            default: begin
                n_fst = F_IDLE;
            end
        endcase
    end

    assign o_rsp.done = (r_fst == F_DONE);
    assign o_rsp.res  = r_res;

endmodule

/* rtl/bracketed_root_finder_step.sv */
// bracketed_root_finder_step: sequencer for a bracketed false-position / bisection search
`timescale 1ns / 1ps

// Accepts one item at a time; o_in_stall is high from a transfer until its result has
// been placed in the output register. A start item passes through S_START2 to S_EMIT and
// the first value item goes straight to S_EMIT. Every later value item of a running
// search runs one multiply first, which alone settles a no-bracket answer; a value item
// with no search running gets an idle answer. When the search goes on, a step then runs
// on the one shared float unit. A bisection step runs an add and a multiply by one half.
// A false-position step runs seven operations in turn; its divide is bit-serial.
// Subnormal operands add pre-normalization to each multiply or divide. Cancellation in
// an add or subtract adds one-bit-per-cycle normalization. Results wait in the output
// register while the next item may already be taken.
module bracketed_root_finder_step import brf_pkg::*; #(
    parameter int BISECT_PERIOD = BISECT_PERIOD_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out
);

    localparam int PW = (BISECT_PERIOD > 1) ? $clog2(BISECT_PERIOD) : 1;
    localparam logic [PW-1:0] PH_INIT = PW'(1 % BISECT_PERIOD);

    t_state  r_state, n_state;
    t_search r_search, n_search;
    logic [63:0] r_lo, n_lo, r_hi, n_hi, r_lv, n_lv, r_hv, n_hv, r_lp, n_lp;
    logic [63:0] r_v, n_v, r_t, n_t, r_mid, n_mid, r_den, n_den, r_p, n_p;
    logic [PW-1:0] r_phase, n_phase;
    t_out r_pend, n_pend, r_out, n_out;
    logic r_ov, n_ov;

    t_fpu_req fpu_req;
    t_fpu_rsp fpu_rsp;

    brf_fpu u_fpu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (fpu_req),
        .o_rsp   (fpu_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_search <= SP_IDLE;
            r_phase  <= PH_INIT;
            r_ov     <= 1'b0;
            r_lo     <= '0;
            r_hi     <= '0;
            r_lv     <= '0;
            r_hv     <= '0;
            r_lp     <= '0;
        end else begin
            r_state  <= n_state;
            r_search <= n_search;
            r_phase  <= n_phase;
            r_ov     <= n_ov;
            r_lo     <= n_lo;
            r_hi     <= n_hi;
            r_lv     <= n_lv;
            r_hv     <= n_hv;
            r_lp     <= n_lp;
        end
        r_v    <= n_v;
        r_t    <= n_t;
        r_mid  <= n_mid;
        r_den  <= n_den;
        r_p    <= n_p;
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    always_comb begin
        logic [63:0] u, w, p2;
        logic        swap;
        logic [PW:0] ph_inc;

        n_state  = r_state;
        n_search = r_search;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_lv     = r_lv;
        n_hv     = r_hv;
        n_lp     = r_lp;
        n_v      = r_v;
        n_t      = r_t;
        n_mid    = r_mid;
        n_den    = r_den;
        n_p      = r_p;
        n_phase  = r_phase;
        n_pend   = r_pend;
        n_out    = r_out;
        n_ov     = r_ov && i_out_stall;
        fpu_req  = '{start: 1'b0, op: FOP_ADD, a: 64'd0, b: 64'd0};

        swap   = fp_lt(i_in.bound_b, i_in.bound_a);
        u      = swap ? i_in.bound_b : i_in.bound_a;
        w      = swap ? i_in.bound_a : i_in.bound_b;
        ph_inc = {1'b0, r_phase} + {{PW{1'b0}}, 1'b1};
        p2     = fp_ulp_toward(r_p, r_lo);

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in.operation == OP_START) begin
                        n_lp     = i_in.bound_a;
                        n_lo     = fp_ulp_toward(u, w);
                        n_hi     = w;
                        n_phase  = PH_INIT;
                        n_search = SP_WAIT_LO;
                        n_state  = S_START2;
                    end else begin
                        case (r_search)
                            SP_WAIT_LO: begin
                                n_lv     = i_in.func_value;
                                n_search = SP_WAIT_HI;
                                n_pend   = '{kind: KIND_EVAL, point: r_hi};
                                n_state  = S_EMIT;
                            end
                            SP_WAIT_HI: begin
                                n_hv    = i_in.func_value;
                                fpu_req = '{start: 1'b1, op: FOP_MUL, a: r_lv,
                                            b: i_in.func_value};
                                n_state = S_PROD;
                            end
                            SP_WAIT_PT: begin
                                n_phase = (ph_inc >= (PW+1)'(BISECT_PERIOD)) ?
                                          '0 : ph_inc[PW-1:0];
                                n_v     = i_in.func_value;
                                fpu_req = '{start: 1'b1, op: FOP_MUL, a: i_in.func_value,
                                            b: r_lv};
                                n_state = S_PROD;
                            end
                            default: begin
                                n_pend  = '{kind: KIND_IDLE, point: 64'd0};
                                n_state = S_EMIT;
                            end
                        endcase
                    end
                end
            end
            S_START2: begin
                n_hi    = fp_ulp_toward(r_hi, r_lo);
                n_pend  = '{kind: KIND_EVAL, point: r_lo};
                n_state = S_EMIT;
            end
            S_PROD: begin
                if (fpu_rsp.done) begin
                    if (r_search == SP_WAIT_HI) begin
                        if (fp_pos(fpu_rsp.res)) begin
                            n_pend   = '{kind: KIND_NOBR, point: r_lo};
                            n_search = SP_IDLE;
                            n_state  = S_EMIT;
                        end else begin
                            n_state = S_ADV;
                        end
                    end else begin
                        if (fp_neg(fpu_rsp.res)) begin
                            n_hv = r_v;
                            n_hi = r_lp;
                        end else begin
                            n_lv = r_v;
                            n_lo = r_lp;
                        end
                        n_state = S_ADV;
                    end
                end
            end
            S_ADV: begin
                if (!fp_lt(r_lo, r_hi)) begin
                    n_pend   = '{kind: KIND_ROOT, point: r_lp};
                    n_search = SP_IDLE;
                    n_state  = S_EMIT;
                end else if (fp_eq(r_hv, 64'd0)) begin
                    n_pend   = '{kind: KIND_ROOT, point: r_hi};
                    n_search = SP_IDLE;
                    n_state  = S_EMIT;
                end else if (fp_eq(r_lv, 64'd0)) begin
                    n_pend   = '{kind: KIND_ROOT, point: r_lo};
                    n_search = SP_IDLE;
                    n_state  = S_EMIT;
                end else begin
                    fpu_req = '{start: 1'b1, op: FOP_ADD, a: r_lo, b: r_hi};
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                if (fpu_rsp.done) begin
                    fpu_req = '{start: 1'b1, op: FOP_MUL, a: ONE_HALF, b: fpu_rsp.res};
                    n_state = S_MID;
                end
            end
            S_MID: begin
                if (fpu_rsp.done) begin
                    n_mid = fpu_rsp.res;
                    if (r_phase != '0) begin
                        fpu_req = '{start: 1'b1, op: FOP_SUB, a: r_hv, b: r_lv};
                        n_state = S_DEN;
                    end else begin
                        n_p     = fpu_rsp.res;
                        n_state = S_FIN;
                    end
                end
            end
            S_DEN: begin
                if (fpu_rsp.done) begin
                    n_den = fpu_rsp.res;
                    if (!fp_eq(fpu_rsp.res, 64'd0)) begin
                        fpu_req = '{start: 1'b1, op: FOP_MUL, a: r_lo, b: r_hv};
                        n_state = S_T1;
                    end else begin
                        n_p     = r_mid;
                        n_state = S_FIN;
                    end
                end
            end
            S_T1: begin
                if (fpu_rsp.done) begin
                    n_t     = fpu_rsp.res;
                    fpu_req = '{start: 1'b1, op: FOP_MUL, a: r_hi, b: r_lv};
                    n_state = S_T2;
                end
            end
            S_T2: begin
                if (fpu_rsp.done) begin
                    fpu_req = '{start: 1'b1, op: FOP_SUB, a: r_t, b: fpu_rsp.res};
                    n_state = S_NUM;
                end
            end
            S_NUM: begin
                if (fpu_rsp.done) begin
                    fpu_req = '{start: 1'b1, op: FOP_DIV, a: fpu_rsp.res, b: r_den};
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (fpu_rsp.done) begin
                    n_p = (fp_lt(fpu_rsp.res, r_lo) || fp_lt(r_hi, fpu_rsp.res)) ?
                          r_mid : fpu_rsp.res;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_lp = p2;
                if (fp_le(p2, r_lo) || fp_le(r_hi, p2)) begin
                    n_pend   = '{kind: KIND_ROOT, point: p2};
                    n_search = SP_IDLE;
                end else begin
                    n_pend   = '{kind: KIND_EVAL, point: p2};
                    n_search = SP_WAIT_PT;
                end
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!r_ov || !i_out_stall) begin
                    n_out   = r_pend;
                    n_ov    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out       = r_out;

endmodule
